// File: src/aes_cbc_pkg.sv
// Shared tables, constants and round functions for the AES-CBC block cipher.
package aes_cbc_pkg;

  localparam int MaxRoundsDefault = 14;
  localparam int BlockW = 128;
  localparam int HalfW  = 64;
  localparam int CfgAddrW = 6;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IVH  = 3'd4;
  localparam logic [2:0] REG_IVL  = 3'd5;
  localparam logic [2:0] REG_KLEN = 3'd6;
  localparam logic [2:0] REG_DIR  = 3'd7;

  // Key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse table, built once at elaboration
  function automatic sbox_arr_t build_inv();
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_arr_t INV_SBOX = build_inv();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int j);
    return s[BlockW-1-8*j -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes, ShiftRows, then MixColumns unless last
  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                  input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [BlockW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int j = 0; j < 16; j++) begin
      r[BlockW-1-8*j -: 8] = t[j];
    end
    return r;
  endfunction

  // InvShiftRows and InvSubBytes
  function automatic logic [BlockW-1:0] dec_sub(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        r[BlockW-1-8*(i + 4*((c + i) % 4)) -: 8] = INV_SBOX[get_byte(s, i + 4*c)];
      end
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    logic [BlockW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = get_byte(s, 4*c + i);
        x2 = xtime(a[i]);
        x4 = xtime(x2);
        x8 = xtime(x4);
        m9[i] = x8 ^ a[i];
        mb[i] = x8 ^ x2 ^ a[i];
        md[i] = x8 ^ x4 ^ a[i];
        me[i] = x8 ^ x4 ^ x2;
      end
      r[BlockW-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      r[BlockW-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      r[BlockW-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      r[BlockW-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return r;
  endfunction

endpackage

// File: src/aes_cbc_block_cipher.sv
// AES-CBC block cipher top level: key schedule sequencer and one shared round unit.
//
// One 128-bit block is taken at a time and runs through a single shared round unit, one
// AES round per cycle, with round keys read from a registered round key store. A block
// goes from acceptance to result through a fetch of the first round key, the initial key
// addition, Nr rounds and a load of the output register. After a write to a key word or
// to the key length, the next block first runs the key schedule, one 32-bit word per
// cycle, 4*(Nr+1) words (44, 52 or 60 for 128-, 192- and 256-bit keys). The input side
// is not ready while a block is in work; a finished result waits in the output register
// while the next block is taken.
module aes_cbc_block_cipher #(
  parameter int MAX_ROUNDS = aes_cbc_pkg::MaxRoundsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aes_cbc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready,
  // input blocks
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [aes_cbc_pkg::BlockW-1:0]    s_tdata,   // block_high, block_low
  input  logic                              s_tuser,   // first_block
  // result blocks
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [aes_cbc_pkg::BlockW-1:0]    m_tdata    // result_high, result_low
);
  import aes_cbc_pkg::*;

  localparam int RoundW = $clog2(MAX_ROUNDS + 1);
  localparam int Words  = 4 * (MAX_ROUNDS + 1);
  localparam int WordW  = $clog2(Words);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_ARK  = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // configuration registers
  logic [HalfW-1:0] key_word [4];
  logic [HalfW-1:0] iv_high, iv_low;
  logic [1:0]       key_length;
  logic             direction;
  logic             keys_ready;
  logic [HalfW-1:0] chain_high, chain_low;

  logic [2:0]        st;
  logic [BlockW-1:0] blk;
  logic [BlockW-1:0] chain;
  logic [BlockW-1:0] acc;
  logic [RoundW-1:0] rd_addr;
  logic [RoundW-1:0] cnt;
  logic              dec;

  // key schedule
  logic [WordW-1:0]  widx;
  logic [2:0]        wmod;
  logic [7:0]        rcon;
  logic [31:0]       win [8];
  logic [31:0]       new_word;
  logic [31:0]       tmp_word;
  logic [3:0]        nk;
  logic [RoundW-1:0] nr;
  logic [WordW-1:0]  last_word;

  logic [BlockW-1:0] rk_mem [MAX_ROUNDS + 1];
  logic [BlockW-1:0] rk_q;
  logic              rk_we;

  logic [2:0]  cfg_idx;
  logic        cfg_wr;
  logic        accept;
  logic        last_round;
  logic [BlockW-1:0] round_out;
  logic [BlockW-1:0] in_block;
  logic [BlockW-1:0] out_block;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[CfgAddrW-1:3];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (st == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Put byte 0 of the block in the top bits
  assign in_block  = {s_tdata[HalfW-1:0], s_tdata[BlockW-1:HalfW]};
  assign out_block = dec ? (acc ^ chain) : acc;

  // Decode rounds and key length from the length code
  always_comb begin
    unique case (key_length)
      KLEN_128: begin
        nk = 4'd4;
        nr = (MAX_ROUNDS < 10) ? RoundW'(MAX_ROUNDS) : RoundW'(10);
      end
      KLEN_192: begin
        nk = 4'd6;
        nr = (MAX_ROUNDS < 12) ? RoundW'(MAX_ROUNDS) : RoundW'(12);
      end
      default: begin
        nk = 4'd8;
        nr = (MAX_ROUNDS < 14) ? RoundW'(MAX_ROUNDS) : RoundW'(14);
      end
    endcase
    last_word = WordW'(4 * (32'(nr) + 1) - 1);
  end

  // Read back registers
  always_comb begin
    unique case (cfg_idx)
      REG_KEY0: prdata = key_word[0];
      REG_KEY1: prdata = key_word[1];
      REG_KEY2: prdata = key_word[2];
      REG_KEY3: prdata = key_word[3];
      REG_IVH:  prdata = iv_high;
      REG_IVL:  prdata = iv_low;
      REG_KLEN: prdata = {62'd0, key_length};
      REG_DIR:  prdata = {63'd0, direction};
      default:  prdata = '0;
    endcase
  end

  // Produce one schedule word: copied key word, or derived from the window
  always_comb begin
    tmp_word = win[0];
    if (wmod == 3'd0) begin
      tmp_word = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'd0};
    end else if (nk == 4'd8 && wmod == 3'd4) begin
      tmp_word = sub_word(win[0]);
    end
    if (widx < WordW'(nk)) begin
      new_word = widx[0] ? key_word[widx[2:1]][31:0] : key_word[widx[2:1]][63:32];
    end else begin
      new_word = win[3'(nk - 4'd1)] ^ tmp_word;
    end
  end

  assign rk_we = (st == ST_KEY) && (widx[1:0] == 2'd3);

  // Round key store with registered read
  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[widx[WordW-1:2]] <= {win[2], win[1], win[0], new_word};
    end
    rk_q <= rk_mem[rd_addr];
  end

  // Shared round unit
  assign last_round = (cnt == nr);
  always_comb begin
    if (dec) begin
      round_out = dec_sub(acc) ^ rk_q;
      if (!last_round) begin
        round_out = inv_mix(round_out);
      end
    end else begin
      round_out = enc_round(acc, last_round) ^ rk_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        key_word[k] <= '0;
      end
      iv_high    <= '0;
      iv_low     <= '0;
      key_length <= KLEN_128;
      direction  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY0: key_word[0] <= pwdata;
        REG_KEY1: key_word[1] <= pwdata;
        REG_KEY2: key_word[2] <= pwdata;
        REG_KEY3: key_word[3] <= pwdata;
        REG_IVH:  iv_high     <= pwdata;
        REG_IVL:  iv_low      <= pwdata;
        REG_KLEN: key_length  <= pwdata[1:0];
        REG_DIR:  direction   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      keys_ready <= 1'b0;
      m_tvalid   <= 1'b0;
      chain_high <= '0;
      chain_low  <= '0;
    end else begin
      if (m_tvalid && m_tready && st != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr && (cfg_idx == REG_KEY0 || cfg_idx == REG_KEY1 || cfg_idx == REG_KEY2 ||
                     cfg_idx == REG_KEY3 || cfg_idx == REG_KLEN)) begin
        keys_ready <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            blk   <= in_block;
            chain <= s_tuser ? {iv_high, iv_low} : {chain_high, chain_low};
            acc   <= direction ? in_block
                     : in_block ^ (s_tuser ? {iv_high, iv_low} : {chain_high, chain_low});
            dec     <= direction;
            rd_addr <= direction ? nr : '0;
            widx    <= '0;
            wmod    <= '0;
            rcon    <= 8'h01;
            st      <= keys_ready ? ST_LOAD : ST_KEY;
          end
        end
        ST_KEY: begin
          for (int k = 7; k > 0; k--) begin
            win[k] <= win[k-1];
          end
          win[0] <= new_word;
          widx   <= widx + 1'b1;
          wmod   <= (wmod == 3'(nk - 4'd1)) ? 3'd0 : wmod + 3'd1;
          if (widx >= WordW'(nk) && wmod == 3'd0) begin
            rcon <= xtime(rcon);
          end
          if (widx == last_word) begin
            keys_ready <= 1'b1;
            st         <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rd_addr <= dec ? rd_addr - 1'b1 : rd_addr + 1'b1;
          st      <= ST_ARK;
        end
        ST_ARK: begin
          acc     <= acc ^ rk_q;
          rd_addr <= dec ? rd_addr - 1'b1 : rd_addr + 1'b1;
          cnt     <= RoundW'(1);
          st      <= ST_RUN;
        end
        ST_RUN: begin
          acc     <= round_out;
          rd_addr <= dec ? rd_addr - 1'b1 : rd_addr + 1'b1;
          cnt     <= cnt + 1'b1;
          if (last_round) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {out_block[HalfW-1:0], out_block[BlockW-1:HalfW]};
            if (dec) begin
              chain_high <= blk[BlockW-1:HalfW];
              chain_low  <= blk[HalfW-1:0];
            end else begin
              chain_high <= acc[BlockW-1:HalfW];
              chain_low  <= acc[HalfW-1:0];
            end
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> st != ST_IDLE)
    else $error("accepted block did not start");

  a_key_only_when_stale: assert property (@(posedge clk) disable iff (rst)
    st == ST_KEY && !$past(cfg_wr) |-> !keys_ready)
    else $error("key schedule running with keys ready");

  a_round_count_bound: assert property (@(posedge clk) disable iff (rst)
    st == ST_RUN |-> cnt <= nr && cnt != '0)
    else $error("round counter out of range");

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    st == ST_FIN && (!m_tvalid || m_tready) |=> m_tvalid && st == ST_IDLE)
    else $error("finished block not delivered");

endmodule
